// ===== sv/cardchk_pkg.sv =====
`default_nettype none
package cardchk_pkg;

  // Field widths and digit counts of the card number, the result and the sequencer counter.
  localparam int CardW       = 63;
  localparam int BcdDigits   = 19;
  localparam int BcdW        = 4 * BcdDigits;
  localparam int DigitCountW = 5;
  localparam int LuhnDigits  = 16;
  localparam int CntW        = 6;

  // Lengths that the brands accept.
  localparam logic [DigitCountW-1:0] LenShort = 5'd13;
  localparam logic [DigitCountW-1:0] LenAmex  = 5'd15;
  localparam logic [DigitCountW-1:0] LenLong  = 5'd16;

  typedef enum logic [1:0] {
    BRAND_INVALID    = 2'd0,
    BRAND_VISA       = 2'd1,
    BRAND_AMEX       = 2'd2,
    BRAND_MASTERCARD = 2'd3
  } brand_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                   load;
    logic                   conv;
    logic                   scan;
    logic                   res_load;
    logic [DigitCountW-1:0] idx;
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/cardchk_dp.sv =====
`default_nettype none
module cardchk_dp (
  input  wire                                   clk_i,
  input  cardchk_pkg::cmd_t                     cmd_i,
  input  wire  [cardchk_pkg::CardW-1:0]         card_number_i,
  output logic [1:0]                            brand_o,
  output logic                                  luhn_ok_o,
  output logic [cardchk_pkg::DigitCountW-1:0]   digit_count_o
);

  localparam int CardW = cardchk_pkg::CardW;
  localparam int BcdW  = cardchk_pkg::BcdW;
  localparam int CntW  = cardchk_pkg::DigitCountW;

  logic [CardW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]  bcd_q, bcd_d, bcd_corr;
  logic [3:0]       acc_q, acc_d, prev_q, prev_d, first_q, first_d, second_q, second_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [1:0]       brand_q, brand_d;
  logic             ok_q, ok_d;
  logic [CntW-1:0]  count_res_q;
  logic [3:0]       digit, weighted;
  logic [4:0]       sum;

  // Doubled digit with its two decimal digits added together.
  function automatic logic [3:0] luhn_double(input logic [3:0] d);
    logic [4:0] twice;
    twice = {d, 1'b0};
    if (d >= 4'd5) begin
      luhn_double = 4'(twice - 5'd9);
    end else begin
      luhn_double = twice[3:0];
    end
  endfunction

  // Shift-and-add-3 correction, each BCD digit on its own.
  always_comb begin
    for (int i = 0; i < cardchk_pkg::BcdDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_corr[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_corr[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Lowest remaining digit, weighted by its place, added modulo ten.
  assign digit    = bcd_q[3:0];
  assign weighted = cmd_i.idx[0] ? luhn_double(digit) : digit;
  always_comb begin
    sum = {1'b0, acc_q} + {1'b0, weighted};
    if (sum >= 5'd10) begin
      sum = sum - 5'd10;
    end
  end

  // Next values of the conversion and scan registers.
  always_comb begin
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    acc_d    = acc_q;
    prev_d   = prev_q;
    first_d  = first_q;
    second_d = second_q;
    count_d  = count_q;
    if (cmd_i.load) begin
      bin_d    = card_number_i;
      bcd_d    = '0;
      acc_d    = '0;
      prev_d   = '0;
      first_d  = '0;
      second_d = '0;
      count_d  = '0;
    end else if (cmd_i.conv) begin
      bcd_d = {bcd_corr[BcdW-2:0], bin_q[CardW-1]};
      bin_d = {bin_q[CardW-2:0], 1'b0};
    end else if (cmd_i.scan) begin
      bcd_d  = {4'd0, bcd_q[BcdW-1:4]};
      prev_d = digit;
      if (cmd_i.idx < CntW'(cardchk_pkg::LuhnDigits)) begin
        acc_d = sum[3:0];
      end
      if (digit != 4'd0) begin
        count_d  = cmd_i.idx + CntW'(1);
        first_d  = digit;
        second_d = prev_q;
      end
    end
  end

  // Brand from the leading pair, the length and the Luhn result.
  always_comb begin
    ok_d    = (acc_q == 4'd0);
    brand_d = cardchk_pkg::BRAND_INVALID;
    if (ok_d) begin
      if (first_q == 4'd4 &&
          (count_q == cardchk_pkg::LenShort || count_q == cardchk_pkg::LenLong)) begin
        brand_d = cardchk_pkg::BRAND_VISA;
      end else if (first_q == 4'd3 && (second_q == 4'd4 || second_q == 4'd7) &&
                   count_q == cardchk_pkg::LenAmex) begin
        brand_d = cardchk_pkg::BRAND_AMEX;
      end else if (first_q == 4'd5 && second_q inside {[4'd1:4'd5]} &&
                   count_q == cardchk_pkg::LenLong) begin
        brand_d = cardchk_pkg::BRAND_MASTERCARD;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q    <= bin_d;
    bcd_q    <= bcd_d;
    acc_q    <= acc_d;
    prev_q   <= prev_d;
    first_q  <= first_d;
    second_q <= second_d;
    count_q  <= count_d;
    if (cmd_i.res_load) begin
      brand_q     <= brand_d;
      ok_q        <= ok_d;
      count_res_q <= count_q;
    end
  end

  assign brand_o       = brand_q;
  assign luhn_ok_o     = ok_q;
  assign digit_count_o = count_res_q;

endmodule
`default_nettype wire

// ===== sv/cardchk_ctrl.sv =====
`default_nettype none
module cardchk_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output cardchk_pkg::cmd_t  cmd_o
);

  localparam int CntW = cardchk_pkg::CntW;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CONV   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  // Sequencer: accept, convert bit by bit, scan digit by digit, hand over.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.idx    = cnt_q[cardchk_pkg::DigitCountW-1:0];
    in_ready_o   = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (cnt_q == CntW'(cardchk_pkg::CardW - 1)) begin
          cnt_d   = '0;
          state_d = ST_SCAN;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (cnt_q == CntW'(cardchk_pkg::BcdDigits - 1)) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_FINISH: begin
        // The result register takes the beat once the previous one has left.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== sv/card_number_luhn_brand_check.sv =====
// Each card number passes a 63-step shift-and-add-3 conversion and then a 19-step
// digit scan through one shared adder before its result is loaded and out_valid_o rises;
// a new number is taken only after the result has been handed to the output register.
// A finished result waits in the output register while the next number is worked on.
// Reset (rst_ni, asynchronous, active low) returns the sequencer to idle and drops
// out_valid_o; the datapath registers are not reset.
`default_nettype none
module card_number_luhn_brand_check (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire  [cardchk_pkg::CardW-1:0]         card_number_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic [1:0]                            brand_o,
  output logic                                  luhn_ok_o,
  output logic [cardchk_pkg::DigitCountW-1:0]   digit_count_o
);

  cardchk_pkg::cmd_t cmd;

  // Sequencer.
  cardchk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Conversion, Luhn sum and brand decision.
  cardchk_dp u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .card_number_i (card_number_i),
    .brand_o       (brand_o),
    .luhn_ok_o     (luhn_ok_o),
    .digit_count_o (digit_count_o)
  );

endmodule
`default_nettype wire

// ===== sv/cardchk_checker.sv =====
`default_nettype none
module cardchk_checker (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 in_valid_i,
  input wire                                 in_ready_o,
  input wire                                 out_valid_o,
  input wire                                 out_ready_i,
  input wire [1:0]                           brand_o,
  input wire                                 luhn_ok_o,
  input wire [cardchk_pkg::DigitCountW-1:0]  digit_count_o
);

  // A stalled result beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(brand_o) &&
    $stable(luhn_ok_o) && $stable(digit_count_o))
    else $error("result beat changed while stalled");

  // The block is busy for the cycle after it takes a card number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  // A named brand requires a passing Luhn check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brand_o != cardchk_pkg::BRAND_INVALID |-> luhn_ok_o)
    else $error("brand given for a number that fails Luhn");

  // A named brand has one of the accepted lengths.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brand_o != cardchk_pkg::BRAND_INVALID |->
    digit_count_o == cardchk_pkg::LenShort || digit_count_o == cardchk_pkg::LenAmex ||
    digit_count_o == cardchk_pkg::LenLong)
    else $error("brand given for a number of wrong length");

endmodule

bind card_number_luhn_brand_check cardchk_checker u_checker (.*);
`default_nettype wire
